>>> rtl/sfrx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_pkg
// Types and constants for the STX/ETX frame receiver with XOR check.
// ----------------------------------------------------------------------------
package sfrx_pkg;

    localparam logic [7:0]  START_BYTE    = 8'h02;
    localparam logic [15:0] MAX_LEN_RESET = 16'd1492;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;

    typedef enum logic [7:0] {
        PH_HUNT  = 8'b0000_0001,
        PH_SER_H = 8'b0000_0010,
        PH_SER_L = 8'b0000_0100,
        PH_LEN_H = 8'b0000_1000,
        PH_LEN_L = 8'b0001_0000,
        PH_DATA  = 8'b0010_0000,
        PH_END   = 8'b0100_0000,
        PH_CHECK = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic [15:0] serial_number;
        logic [15:0] frame_length;
        logic [7:0]  computed_check;
        logic [7:0]  received_check;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/sfrx_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_in_if
// Byte input channel: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface sfrx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/sfrx_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_out_if
// Result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface sfrx_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_offset;
    logic [15:0] serial_number;
    logic [15:0] frame_length;
    logic [7:0]  computed_check;
    logic [7:0]  received_check;

    modport source (
        output valid, output kind, output data_byte, output byte_offset,
        output serial_number, output frame_length, output computed_check,
        output received_check, input ready
    );
    modport sink (
        input valid, input kind, input data_byte, input byte_offset,
        input serial_number, input frame_length, input computed_check,
        input received_check, output ready
    );
endinterface
`default_nettype wire

>>> rtl/sfrx_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfrx_core
// Frame parser: phase tracking, header capture, payload count and XOR check.
// ----------------------------------------------------------------------------
module sfrx_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [15:0]      cfg_wdata,
    input  wire logic             accept,
    input  wire logic [7:0]       in_byte,
    output      logic             res_valid,
    output      sfrx_pkg::result_t res
);
    import sfrx_pkg::*;

    phase_t      phase_reg,     phase_next;
    logic [15:0] serial_reg,    serial_next;
    logic [15:0] length_reg,    length_next;
    logic [15:0] remaining_reg, remaining_next;
    logic [7:0]  check_reg,     check_next;
    logic [15:0] max_len_reg;
    logic [15:0] len_full;

    assign len_full = {length_reg[15:8], in_byte};

    always_comb
    begin
        phase_next     = phase_reg;
        serial_next    = serial_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        check_next     = check_reg;
        res_valid      = 1'b0;
        res            = '0;
        res.serial_number = serial_reg;
        res.frame_length  = length_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (in_byte == START_BYTE)
                begin
                    check_next     = in_byte;
                    serial_next    = '0;
                    length_next    = '0;
                    remaining_next = '0;
                    phase_next     = PH_SER_H;
                end
            end
            PH_SER_H:
            begin
                serial_next = {in_byte, 8'h00};
                check_next  = check_reg ^ in_byte;
                phase_next  = PH_SER_L;
            end
            PH_SER_L:
            begin
                serial_next = {serial_reg[15:8], in_byte};
                check_next  = check_reg ^ in_byte;
                phase_next  = PH_LEN_H;
            end
            PH_LEN_H:
            begin
                length_next = {in_byte, 8'h00};
                check_next  = check_reg ^ in_byte;
                phase_next  = PH_LEN_L;
            end
            PH_LEN_L:
            begin
                length_next = len_full;
                if (len_full > max_len_reg)
                begin
                    check_next = '0;
                    phase_next = PH_HUNT;
                end
                else
                begin
                    check_next     = check_reg ^ in_byte;
                    remaining_next = len_full;
                    phase_next     = (len_full == 16'd0) ? PH_END : PH_DATA;
                end
            end
            PH_DATA:
            begin
                check_next      = check_reg ^ in_byte;
                res_valid       = 1'b1;
                res.kind        = KIND_PAYLOAD;
                res.data_byte   = in_byte;
                res.byte_offset = length_reg - remaining_reg;
                remaining_next  = remaining_reg - 16'd1;
                if (remaining_reg == 16'd1)
                    phase_next = PH_END;
            end
            PH_END:
            begin
                check_next = check_reg ^ in_byte;
                phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                res_valid          = 1'b1;
                res.kind           = (in_byte == check_reg) ? KIND_GOOD : KIND_MISMATCH;
                res.computed_check = check_reg;
                res.received_check = in_byte;
                check_next         = '0;
                phase_next         = PH_HUNT;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HUNT;
            serial_reg    <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            check_reg     <= '0;
            max_len_reg   <= MAX_LEN_RESET;
        end
        else
        begin
            if (cfg_we)
                max_len_reg <= cfg_wdata;
            if (accept)
            begin
                phase_reg     <= phase_next;
                serial_reg    <= serial_next;
                length_reg    <= length_next;
                remaining_reg <= remaining_next;
                check_reg     <= check_next;
            end
        end
    end

    // payload phase always has bytes left to take
    a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (remaining_reg != 16'd0))
        else $error("payload phase with zero remaining count");

    a_check_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && phase_reg == PH_CHECK) |=> (phase_reg == PH_HUNT && check_reg == 8'h00))
        else $error("check byte did not return to hunt");

    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (remaining_reg <= length_reg))
        else $error("remaining count exceeds frame length");

endmodule
`default_nettype wire

>>> rtl/stx_frame_receiver_xor_check_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stx_frame_receiver_xor_check_top
// STX/ETX frame receiver with XOR longitudinal check.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received byte per item. The block hunts for the start
//   byte, captures serial number and length, and emits one item on out_ch
//   for each payload byte (with its offset) and one at the check byte
//   (check good or mismatch). Other bytes produce no item.
//   cfg_we/cfg_wdata write the maximum payload length (reset 1492); a longer
//   frame is dropped without any item.
// Output: a result is registered when its byte is accepted; out_ch shows it
//   in the next cycle. Throughput: one byte per cycle unless out_ch stalls;
//   each accepted byte updates the parser state and running XOR, and the
//   result register is refilled in the same cycle it is taken.
// Reset: the parser returns to hunting for the start byte, the result
//   register is emptied and the maximum length returns to 1492.
// Stall: while a result waits and out_ch.ready is low, in_ch.ready is low.
// ----------------------------------------------------------------------------
module stx_frame_receiver_xor_check_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [15:0] cfg_wdata,
    sfrx_in_if.sink    in_ch,
    sfrx_out_if.source out_ch
);
    import sfrx_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    out_valid_reg;
    result_t out_res_reg;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    sfrx_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .in_byte   (in_ch.in_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && res_valid)
            out_res_reg <= res;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.kind           = out_res_reg.kind;
    assign out_ch.data_byte      = out_res_reg.data_byte;
    assign out_ch.byte_offset    = out_res_reg.byte_offset;
    assign out_ch.serial_number  = out_res_reg.serial_number;
    assign out_ch.frame_length   = out_res_reg.frame_length;
    assign out_ch.computed_check = out_res_reg.computed_check;
    assign out_ch.received_check = out_res_reg.received_check;

    a_kind_match: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.kind != KIND_PAYLOAD) |->
        ((out_res_reg.kind == KIND_GOOD) ==
         (out_res_reg.computed_check == out_res_reg.received_check)))
        else $error("check result kind disagrees with check bytes");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_res_reg.kind != 2'd3))
        else $error("illegal result kind");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_res_reg.kind == KIND_PAYLOAD) |->
        (out_res_reg.computed_check == 8'h00 && out_res_reg.received_check == 8'h00))
        else $error("payload item carries check fields");

endmodule
`default_nettype wire
